>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the date/time adder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds whenever out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants, microcode and helper functions of the date/time adder.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam int YEAR_LIMIT_DEF     = 10000;
  localparam int DAY_OFFSET_MAX_DEF = 1023;
  localparam int YEAR_RESET         = 2000;
  localparam int YEAR_IN_W          = 14;
  localparam int DAY_SUM_W          = 11;
  localparam int PC_W               = 3;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_FEB_L = 5'd29;
  localparam logic [4:0] DAYS_FEB   = 5'd28;

  localparam logic OPC_ADD  = 1'b0;
  localparam logic OPC_LOAD = 1'b1;

  localparam logic LEAP_SEL_DATE = 1'b0;
  localparam logic LEAP_SEL_OPND = 1'b1;

  typedef logic [PC_W-1:0] cda_pc_t;

  localparam cda_pc_t PC_IDLE     = 3'd0;
  localparam cda_pc_t PC_SETTLE_I = 3'd1;
  localparam cda_pc_t PC_VALIDATE = 3'd2;
  localparam cda_pc_t PC_TIME     = 3'd3;
  localparam cda_pc_t PC_SETTLE_D = 3'd4;
  localparam cda_pc_t PC_WALK     = 3'd5;
  localparam cda_pc_t PC_DONE     = 3'd6;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_VALIDATE,
    DP_TIME,
    DP_WALK
  } cda_dp_op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_START,
    CND_NO_ADD,
    CND_DAY_OVER
  } cda_cond_e;

  typedef struct packed {
    cda_dp_op_e op;
    logic       leap_sel;
    logic       done;
  } cda_ctrl_t;

  typedef struct packed {
    logic bad;
    logic is_load;
    logic day_over;
  } cda_status_t;

  typedef struct packed {
    cda_ctrl_t ctrl;
    logic      busy;
    cda_cond_e cond;
    cda_pc_t   target;
  } cda_uword_t;

  function automatic cda_uword_t ucode(input cda_pc_t pc);
    cda_uword_t w;
    w = '{ctrl: '{op: DP_NOP, leap_sel: LEAP_SEL_DATE, done: 1'b0},
           busy: 1'b1, cond: CND_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.ctrl.op = DP_CAPTURE;
        w.busy    = 1'b0;
        w.cond    = CND_NO_START;
        w.target  = PC_IDLE;
      end
      PC_SETTLE_I: begin
        w.ctrl.leap_sel = LEAP_SEL_OPND;
        w.cond          = CND_NEVER;
      end
      PC_VALIDATE: begin
        w.ctrl.op = DP_VALIDATE;
        w.cond    = CND_NO_ADD;
        w.target  = PC_DONE;
      end
      PC_TIME: begin
        w.ctrl.op = DP_TIME;
        w.cond    = CND_NEVER;
      end
      PC_SETTLE_D: begin
        w.cond = CND_NEVER;
      end
      PC_WALK: begin
        w.ctrl.op = DP_WALK;
        w.cond    = CND_DAY_OVER;
        w.target  = PC_WALK;
      end
      PC_DONE: begin
        w.ctrl.done = 1'b1;
        w.cond      = CND_ALWAYS;
        w.target    = PC_IDLE;
      end
      default: begin
        w.cond   = CND_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      MONTH_FEB: d = leap ? DAYS_FEB_L : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = DAYS_SHORT;
      default: d = DAYS_LONG;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cda_leap.sv
// ----------------------------------------------------------------------------
// cda_leap
// Registered Gregorian leap-year test: divisibility by 25 through the
// modular inverse, by 4 and 16 through the low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_leap #(
  parameter int YEAR_W = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [YEAR_W-1:0] year_i,
  output logic                   leap_o
);

  localparam int XW = YEAR_W - 2;

  function automatic logic [31:0] inv_of_25();
    logic [31:0] v;
    v = 32'd25;
    for (int i = 0; i < 4; i++) begin
      v = v * (32'd2 - 32'd25 * v);
    end
    return v;
  endfunction

  localparam logic [XW-1:0] INV25 = XW'(inv_of_25());
  localparam logic [XW-1:0] LIM25 = XW'(((2 ** XW) - 1) / 25);

  logic [XW-1:0] quarter;
  logic [XW-1:0] prod;
  logic          div25;
  logic          leap_d;
  logic          leap_q;

  assign quarter = year_i[YEAR_W-1:2];
  assign prod    = XW'(quarter * INV25);
  assign div25   = (prod <= LIM25);
  assign leap_d  = (year_i[1:0] == 2'b00) && (!div25 || (year_i[3:2] == 2'b00));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leap_q <= 1'b0;
    end else begin
      leap_q <= leap_d;
    end
  end

  assign leap_o = leap_q;

endmodule

`default_nettype wire

>>> hdl/cda_datapath.sv
// ----------------------------------------------------------------------------
// cda_datapath
// Date/time registers, operand latch, carry adders and the month walk,
// driven one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cda_datapath #(
  parameter int YEAR_LIMIT     = cda_pkg::YEAR_LIMIT_DEF,
  parameter int DAY_OFFSET_MAX = cda_pkg::DAY_OFFSET_MAX_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cda_pkg::cda_ctrl_t   ctrl_i,
  output cda_pkg::cda_status_t      status_o,
  input  wire logic                 opcode_i,
  input  wire logic [13:0]          year_value_i,
  input  wire logic [3:0]           month_value_i,
  input  wire logic [9:0]           day_value_i,
  input  wire logic [4:0]           hour_value_i,
  input  wire logic [5:0]           minute_value_i,
  input  wire logic [5:0]           second_value_i,
  output logic                      accepted_o,
  output logic                      year_wrapped_o,
  output logic [13:0]               cur_year_o,
  output logic [3:0]                cur_month_o,
  output logic [4:0]                cur_day_o,
  output logic [4:0]                cur_hour_o,
  output logic [5:0]                cur_minute_o,
  output logic [5:0]                cur_second_o
);

  localparam int YEAR_W = (YEAR_LIMIT > (2 ** cda_pkg::YEAR_IN_W)) ?
                          $clog2(YEAR_LIMIT) : cda_pkg::YEAR_IN_W;
  localparam int DW     = cda_pkg::DAY_SUM_W;
  localparam logic [YEAR_W:0] YL_C   = (YEAR_W + 1)'(YEAR_LIMIT);
  localparam logic [16:0]     DOFF_C = 17'(DAY_OFFSET_MAX);

  logic              op_q;
  logic [13:0]       yv_q;
  logic [3:0]        mv_q;
  logic [9:0]        dv_q;
  logic [4:0]        hv_q;
  logic [5:0]        nv_q;
  logic [5:0]        sv_q;

  logic [YEAR_W-1:0] year_q, year_d;
  logic [3:0]        month_q, month_d;
  logic [4:0]        day_q, day_d;
  logic [4:0]        hour_q, hour_d;
  logic [5:0]        min_q, min_d;
  logic [5:0]        sec_q, sec_d;
  logic [DW-1:0]     dsum_q, dsum_d;
  logic              ok_q, ok_d;
  logic              wrap_q, wrap_d;

  logic [YEAR_W-1:0] leap_year;
  logic              leap;
  logic              time_ok;
  logic              year_ok;
  logic              ok_load;
  logic              ok_add;
  logic              ok_now;
  logic [4:0]        dim_in;
  logic [4:0]        dim;
  logic              day_over;

  logic [6:0]        s_sum;
  logic [6:0]        n_sum;
  logic [5:0]        h_sum;
  logic [4:0]        m_sum;
  logic              c_s, c_n, c_h, c_m;
  logic [YEAR_W:0]   y_add;
  logic [YEAR_W:0]   y_sum;
  logic              y_wrap;
  logic [YEAR_W-1:0] y_new;

  assign leap_year = (ctrl_i.leap_sel == cda_pkg::LEAP_SEL_OPND) ? YEAR_W'(yv_q) : year_q;

  cda_leap #(
    .YEAR_W (YEAR_W)
  ) u_leap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .year_i (leap_year),
    .leap_o (leap)
  );

  // validation
  assign time_ok = (hv_q <= cda_pkg::HOUR_MAX) && (nv_q <= cda_pkg::MIN_MAX) &&
                   (sv_q <= cda_pkg::SEC_MAX);
  assign year_ok = ((YEAR_W + 1)'(yv_q) < YL_C);
  assign dim_in  = cda_pkg::month_days(mv_q, leap);
  assign ok_load = time_ok && year_ok && (mv_q >= 4'd1) && (mv_q <= cda_pkg::MONTH_MAX) &&
                   (dv_q >= 10'd1) && (dv_q <= 10'(dim_in));
  assign ok_add  = time_ok && year_ok && (mv_q <= cda_pkg::MONTH_MAX) &&
                   (17'(dv_q) <= DOFF_C);
  assign ok_now  = (op_q == cda_pkg::OPC_LOAD) ? ok_load : ok_add;

  // carry chain
  assign s_sum = 7'(sec_q) + 7'(sv_q);
  assign c_s   = (s_sum > 7'(cda_pkg::SEC_MAX));
  assign n_sum = 7'(min_q) + 7'(nv_q) + 7'(c_s);
  assign c_n   = (n_sum > 7'(cda_pkg::MIN_MAX));
  assign h_sum = 6'(hour_q) + 6'(hv_q) + 6'(c_n);
  assign c_h   = (h_sum > 6'(cda_pkg::HOUR_MAX));
  assign m_sum = 5'(month_q) + 5'(mv_q);
  assign c_m   = (m_sum > 5'(cda_pkg::MONTH_MAX));

  // shared year adder: offset plus month carry, or one from the walk
  assign y_add  = (ctrl_i.op == cda_pkg::DP_TIME) ?
                  ((YEAR_W + 1)'(yv_q) + (YEAR_W + 1)'(c_m)) : (YEAR_W + 1)'(1);
  assign y_sum  = (YEAR_W + 1)'(year_q) + y_add;
  assign y_wrap = (y_sum >= YL_C);
  assign y_new  = y_wrap ? YEAR_W'(y_sum - YL_C) : YEAR_W'(y_sum);

  // month walk
  assign dim      = cda_pkg::month_days(month_q, leap);
  assign day_over = (dsum_q > DW'(dim));

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    dsum_d  = dsum_q;
    ok_d    = ok_q;
    wrap_d  = wrap_q;
    case (ctrl_i.op)
      cda_pkg::DP_VALIDATE: begin
        ok_d   = ok_now;
        wrap_d = 1'b0;
        if (ok_now && (op_q == cda_pkg::OPC_LOAD)) begin
          year_d  = YEAR_W'(yv_q);
          month_d = mv_q;
          day_d   = 5'(dv_q);
          hour_d  = hv_q;
          min_d   = nv_q;
          sec_d   = sv_q;
        end
      end
      cda_pkg::DP_TIME: begin
        sec_d   = c_s ? 6'(s_sum - 7'd60) : 6'(s_sum);
        min_d   = c_n ? 6'(n_sum - 7'd60) : 6'(n_sum);
        hour_d  = c_h ? 5'(h_sum - 6'd24) : 5'(h_sum);
        dsum_d  = DW'(day_q) + DW'(dv_q) + DW'(c_h);
        month_d = c_m ? 4'(m_sum - 5'(cda_pkg::MONTH_MAX)) : 4'(m_sum);
        year_d  = y_new;
        wrap_d  = y_wrap;
      end
      cda_pkg::DP_WALK: begin
        if (day_over) begin
          dsum_d = dsum_q - DW'(dim);
          if (month_q == cda_pkg::MONTH_MAX) begin
            month_d = 4'd1;
            year_d  = y_new;
            wrap_d  = wrap_q | y_wrap;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          day_d = 5'(dsum_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= YEAR_W'(cda_pkg::YEAR_RESET);
      month_q <= 4'd1;
      day_q   <= 5'd1;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      ok_q    <= 1'b0;
      wrap_q  <= 1'b0;
    end else begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      ok_q    <= ok_d;
      wrap_q  <= wrap_d;
    end
  end

  // operands and walk sum hold no control state
  always_ff @(posedge clk_i) begin
    dsum_q <= dsum_d;
    if (ctrl_i.op == cda_pkg::DP_CAPTURE) begin
      op_q <= opcode_i;
      yv_q <= year_value_i;
      mv_q <= month_value_i;
      dv_q <= day_value_i;
      hv_q <= hour_value_i;
      nv_q <= minute_value_i;
      sv_q <= second_value_i;
    end
  end

  assign status_o.bad      = !ok_now;
  assign status_o.is_load  = (op_q == cda_pkg::OPC_LOAD);
  assign status_o.day_over = day_over;

  assign accepted_o     = ok_q;
  assign year_wrapped_o = wrap_q;
  assign cur_year_o     = year_q[13:0];
  assign cur_month_o    = month_q;
  assign cur_day_o      = day_q;
  assign cur_hour_o     = hour_q;
  assign cur_minute_o   = min_q;
  assign cur_second_o   = sec_q;

  `ASSERT_IMPLIES(a_wrap_needs_ok, clk_i, rst_ni, ctrl_i.done && !ok_q, !wrap_q)
  `ASSERT_IMPLIES(a_date_range, clk_i, rst_ni, ctrl_i.done, (month_q >= 4'd1) && (month_q <= cda_pkg::MONTH_MAX) && (day_q >= 5'd1))
  `ASSERT_IMPLIES(a_year_below_limit, clk_i, rst_ni, ctrl_i.done && ok_q, (YEAR_W + 1)'(year_q) < YL_C)

endmodule

`default_nettype wire

>>> hdl/cda_sequencer.sv
// ----------------------------------------------------------------------------
// cda_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cda_sequencer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire cda_pkg::cda_status_t status_i,
  output cda_pkg::cda_ctrl_t        ctrl_o,
  output logic                      busy,
  output logic                      done_o
);

  cda_pkg::cda_pc_t    pc_q, pc_d;
  cda_pkg::cda_uword_t uword;
  logic                jump;

  assign uword = cda_pkg::ucode(pc_q);

  always_comb begin
    case (uword.cond)
      cda_pkg::CND_ALWAYS:   jump = 1'b1;
      cda_pkg::CND_NO_START: jump = !start;
      cda_pkg::CND_NO_ADD:   jump = status_i.bad || status_i.is_load;
      cda_pkg::CND_DAY_OVER: jump = status_i.day_over;
      default:               jump = 1'b0;
    endcase
    pc_d = jump ? uword.target : pc_q + cda_pkg::cda_pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cda_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = uword.ctrl;
  assign busy   = uword.busy;
  assign done_o = uword.ctrl.done;

  `ASSERT_NEXT(a_start_goes_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_NEXT(a_done_then_idle, clk_i, rst_ni, done_o, !busy && !done_o)

endmodule

`default_nettype wire

>>> hdl/calendar_datetime_adder.sv
// A load or a rejected item strobes done_o after the operand settle and validate steps;
// an add runs the time, date settle and month-walk steps before done_o.
// The month walk retires one month per cycle; the day sum walks at most 34 months.
// A new item is taken in the cycle after done_o, when busy falls; no output stall.
// Reset: date and time 2000-01-01 00:00:00, flags clear, step counter at idle.
// ----------------------------------------------------------------------------
// calendar_datetime_adder
// Gregorian date/time register with validated load and carried add, run by a
// microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_datetime_adder #(
  parameter int YEAR_LIMIT     = cda_pkg::YEAR_LIMIT_DEF,
  parameter int DAY_OFFSET_MAX = cda_pkg::DAY_OFFSET_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode_i,
  input  wire logic [13:0] year_value_i,
  input  wire logic [3:0]  month_value_i,
  input  wire logic [9:0]  day_value_i,
  input  wire logic [4:0]  hour_value_i,
  input  wire logic [5:0]  minute_value_i,
  input  wire logic [5:0]  second_value_i,
  output logic             done_o,
  output logic             accepted_o,
  output logic             year_wrapped_o,
  output logic [13:0]      cur_year_o,
  output logic [3:0]       cur_month_o,
  output logic [4:0]       cur_day_o,
  output logic [4:0]       cur_hour_o,
  output logic [5:0]       cur_minute_o,
  output logic [5:0]       cur_second_o
);

  cda_pkg::cda_ctrl_t   ctrl;
  cda_pkg::cda_status_t status;

  cda_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy),
    .done_o   (done_o)
  );

  cda_datapath #(
    .YEAR_LIMIT     (YEAR_LIMIT),
    .DAY_OFFSET_MAX (DAY_OFFSET_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .year_value_i   (year_value_i),
    .month_value_i  (month_value_i),
    .day_value_i    (day_value_i),
    .hour_value_i   (hour_value_i),
    .minute_value_i (minute_value_i),
    .second_value_i (second_value_i),
    .accepted_o     (accepted_o),
    .year_wrapped_o (year_wrapped_o),
    .cur_year_o     (cur_year_o),
    .cur_month_o    (cur_month_o),
    .cur_day_o      (cur_day_o),
    .cur_hour_o     (cur_hour_o),
    .cur_minute_o   (cur_minute_o),
    .cur_second_o   (cur_second_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/calendar_datetime_checker.sv
// ----------------------------------------------------------------------------
// calendar_datetime_checker
// Watches the command and result strobes of the date/time adder and keeps its
// own calendar state. Each command transfer queues a predicted result. Each
// done strobe is compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module calendar_datetime_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        opcode_i,
  input  logic [13:0] year_value_i,
  input  logic [3:0]  month_value_i,
  input  logic [9:0]  day_value_i,
  input  logic [4:0]  hour_value_i,
  input  logic [5:0]  minute_value_i,
  input  logic [5:0]  second_value_i,
  input  logic        done_i,
  input  logic        accepted_i,
  input  logic        year_wrapped_i,
  input  logic [13:0] cur_year_i,
  input  logic [3:0]  cur_month_i,
  input  logic [4:0]  cur_day_i,
  input  logic [4:0]  cur_hour_i,
  input  logic [5:0]  cur_minute_i,
  input  logic [5:0]  cur_second_i,
  output int          fail_count_o,
  output int          pending_o
);
  import cda_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic        year_wrapped;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_result_t;

  datetime_result_t expected_dates[$];

  int unsigned cal_year   = YEAR_RESET;
  int unsigned cal_month  = 1;
  int unsigned cal_day    = 1;
  int unsigned cal_hour   = 0;
  int unsigned cal_minute = 0;
  int unsigned cal_second = 0;
  bit          year_wrapped = 1'b0;
  int          fail_count = 0;
  int          pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      MONTH_FEB: return leap ? DAYS_FEB_L : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
      default: return DAYS_LONG;
    endcase
  endfunction

  function automatic void advance_year(input int unsigned add);
    cal_year += add;
    if (cal_year >= YEAR_LIMIT_DEF) begin
      cal_year %= YEAR_LIMIT_DEF;
      year_wrapped = 1'b1;
    end
  endfunction

  function automatic datetime_result_t apply_datetime_op(
    input logic op, input int unsigned yv, input int unsigned mv, input int unsigned dv,
    input int unsigned hv, input int unsigned nv, input int unsigned sv);
    datetime_result_t r;
    bit               ok;
    bit               time_ok;
    int unsigned      day_sum;
    int unsigned      dim;
    year_wrapped = 1'b0;
    time_ok = (hv <= HOUR_MAX) && (nv <= MIN_MAX) && (sv <= SEC_MAX);
    if (op == OPC_LOAD) begin
      ok = time_ok && yv < YEAR_LIMIT_DEF && mv >= 1 && mv <= MONTH_MAX &&
           dv >= 1 && dv <= month_length(mv, yv);
      if (ok) begin
        cal_year   = yv;
        cal_month  = mv;
        cal_day    = dv;
        cal_hour   = hv;
        cal_minute = nv;
        cal_second = sv;
      end
    end else begin
      ok = time_ok && yv < YEAR_LIMIT_DEF && mv <= MONTH_MAX && dv <= DAY_OFFSET_MAX_DEF;
      if (ok) begin
        cal_second += sv;
        cal_minute += nv;
        cal_hour   += hv;
        cal_month  += mv;
        day_sum     = cal_day + dv;
        if (cal_second > SEC_MAX) begin
          cal_second -= 60;
          cal_minute += 1;
        end
        if (cal_minute > MIN_MAX) begin
          cal_minute -= 60;
          cal_hour   += 1;
        end
        if (cal_hour > HOUR_MAX) begin
          cal_hour -= 24;
          day_sum  += 1;
        end
        if (cal_month > MONTH_MAX) begin
          cal_month -= 12;
          advance_year(yv + 1);
        end else begin
          advance_year(yv);
        end
        // walk the day sum one month at a time
        dim = month_length(cal_month, cal_year);
        while (day_sum > dim) begin
          day_sum   -= dim;
          cal_month += 1;
          if (cal_month > MONTH_MAX) begin
            cal_month = 1;
            advance_year(1);
          end
          dim = month_length(cal_month, cal_year);
        end
        cal_day = day_sum;
      end
    end
    r.accepted     = ok;
    r.year_wrapped = year_wrapped;
    r.year         = cal_year[13:0];
    r.month        = cal_month[3:0];
    r.day          = cal_day[4:0];
    r.hour         = cal_hour[4:0];
    r.minute       = cal_minute[5:0];
    r.second       = cal_second[5:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    datetime_result_t exp_res;
    if (!rst_ni) begin
      cal_year   = YEAR_RESET;
      cal_month  = 1;
      cal_day    = 1;
      cal_hour   = 0;
      cal_minute = 0;
      cal_second = 0;
      expected_dates.delete();
      pending = 0;
    end else begin
      if (done_i) begin
        if (expected_dates.size() == 0) begin
          $error("result strobe with no transfer outstanding");
          fail_count++;
        end else begin
          exp_res = expected_dates.pop_front();
          check_field("accepted", exp_res.accepted, accepted_i);
          check_field("year_wrapped", exp_res.year_wrapped, year_wrapped_i);
          check_field("cur_year", exp_res.year, cur_year_i);
          check_field("cur_month", exp_res.month, cur_month_i);
          check_field("cur_day", exp_res.day, cur_day_i);
          check_field("cur_hour", exp_res.hour, cur_hour_i);
          check_field("cur_minute", exp_res.minute, cur_minute_i);
          check_field("cur_second", exp_res.second, cur_second_i);
        end
      end
      if (start_i && !busy_i) begin
        expected_dates.push_back(apply_datetime_op(opcode_i, year_value_i, month_value_i,
          day_value_i, hour_value_i, minute_value_i, second_value_i));
      end
      pending = expected_dates.size();
    end
  end

endmodule

>>> tb/sv/tb_calendar_datetime_adder.sv
// ----------------------------------------------------------------------------
// tb_calendar_datetime_adder
// Drives load and add commands into the date/time adder: a directed set of
// calendar corner cases, then random commands that are mostly well formed
// with some raw noise, with random sender idling. Checking is done by the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_calendar_datetime_adder;
  import cda_pkg::*;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        opcode_i       = OPC_ADD;
  logic [13:0] year_value_i   = '0;
  logic [3:0]  month_value_i  = '0;
  logic [9:0]  day_value_i    = '0;
  logic [4:0]  hour_value_i   = '0;
  logic [5:0]  minute_value_i = '0;
  logic [5:0]  second_value_i = '0;

  logic        busy;
  logic        done_o;
  logic        accepted_o;
  logic        year_wrapped_o;
  logic [13:0] cur_year_o;
  logic [3:0]  cur_month_o;
  logic [4:0]  cur_day_o;
  logic [4:0]  cur_hour_o;
  logic [5:0]  cur_minute_o;
  logic [5:0]  cur_second_o;

  int fail_count;
  int pending;
  int idle_pct = 10;

  calendar_datetime_adder uut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .year_value_i, .month_value_i,
    .day_value_i, .hour_value_i, .minute_value_i, .second_value_i, .done_o,
    .accepted_o, .year_wrapped_o, .cur_year_o, .cur_month_o, .cur_day_o,
    .cur_hour_o, .cur_minute_o, .cur_second_o
  );

  calendar_datetime_checker u_checker (
    .clk_i, .rst_ni,
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i, .year_value_i, .month_value_i, .day_value_i, .hour_value_i,
    .minute_value_i, .second_value_i,
    .done_i         (done_o),
    .accepted_i     (accepted_o),
    .year_wrapped_i (year_wrapped_o),
    .cur_year_i     (cur_year_o),
    .cur_month_i    (cur_month_o),
    .cur_day_i      (cur_day_o),
    .cur_hour_i     (cur_hour_o),
    .cur_minute_i   (cur_minute_o),
    .cur_second_i   (cur_second_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic send_datetime_op(input logic op, input logic [13:0] y, input logic [3:0] m,
                                  input logic [9:0] d, input logic [4:0] h,
                                  input logic [5:0] n, input logic [5:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      opcode_i       <= 1'($urandom);
      year_value_i   <= 14'($urandom);
      month_value_i  <= 4'($urandom);
      day_value_i    <= 10'($urandom);
      hour_value_i   <= 5'($urandom);
      minute_value_i <= 6'($urandom);
      second_value_i <= 6'($urandom);
      @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    year_value_i   <= y;
    month_value_i  <= m;
    day_value_i    <= d;
    hour_value_i   <= h;
    minute_value_i <= n;
    second_value_i <= s;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results;
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned h;
    int unsigned n;
    int unsigned s;
    int unsigned kind;
    logic        op;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_datetime_op(OPC_LOAD, 2024, 2, 29, 23, 59, 59);
    send_datetime_op(OPC_ADD, 0, 0, 0, 0, 0, 1);
    send_datetime_op(OPC_LOAD, 2023, 2, 29, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 1900, 2, 29, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 2000, 2, 29, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 0, 2, 29, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 10000, 1, 1, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 16383, 15, 1023, 31, 63, 63);
    send_datetime_op(OPC_LOAD, 2021, 0, 1, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 2021, 13, 1, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 2021, 4, 31, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 2021, 4, 0, 0, 0, 0);
    send_datetime_op(OPC_LOAD, 2021, 1, 1, 24, 0, 0);
    send_datetime_op(OPC_LOAD, 2021, 1, 1, 0, 60, 0);
    send_datetime_op(OPC_LOAD, 2021, 1, 1, 0, 0, 60);
    send_datetime_op(OPC_LOAD, 2023, 1, 31, 12, 0, 0);
    send_datetime_op(OPC_ADD, 0, 1, 0, 0, 0, 0);
    send_datetime_op(OPC_ADD, 10000, 0, 0, 0, 0, 0);
    send_datetime_op(OPC_ADD, 0, 13, 0, 0, 0, 0);
    send_datetime_op(OPC_ADD, 0, 0, 0, 24, 0, 0);
    send_datetime_op(OPC_ADD, 0, 0, 0, 0, 60, 0);
    send_datetime_op(OPC_ADD, 0, 0, 0, 0, 0, 60);
    send_datetime_op(OPC_LOAD, 9999, 12, 31, 23, 59, 59);
    send_datetime_op(OPC_ADD, 0, 0, 0, 0, 0, 1);
    send_datetime_op(OPC_ADD, 9999, 12, 1023, 23, 59, 59);
    send_datetime_op(OPC_ADD, 0, 0, 0, 0, 0, 0);
    drain_results();

    for (int i = 0; i < 1850; i++) begin
      idle_pct = (i >= 700 && i < 1000) ? 0 : 10;
      if (i % 400 == 399) drain_results();
      kind = $urandom_range(99);
      if (kind < 30) begin
        op = OPC_LOAD;
        case ($urandom_range(4))
          0: y = $urandom_range(9999);
          1: y = 9999 - $urandom_range(3);
          2: y = $urandom_range(3);
          3: y = 1900 + 100 * $urandom_range(5);
          default: y = $urandom_range(1999, 2101);
        endcase
        m = $urandom_range(1, 12);
        d = ($urandom_range(7) == 0) ? $urandom_range(29, 32) : $urandom_range(1, 28);
        h = $urandom_range(23);
        n = $urandom_range(59);
        s = $urandom_range(59);
      end else if (kind < 85) begin
        op = OPC_ADD;
        y = ($urandom_range(9) == 0) ? $urandom_range(9999) : $urandom_range(2);
        m = $urandom_range(12);
        case ($urandom_range(3))
          0: d = $urandom_range(31);
          1: d = $urandom_range(1023);
          2: d = 1023 - $urandom_range(3);
          default: d = $urandom_range(400);
        endcase
        h = ($urandom_range(4) == 0) ? 23 : $urandom_range(23);
        n = ($urandom_range(4) == 0) ? 59 : $urandom_range(59);
        s = ($urandom_range(4) == 0) ? 59 : $urandom_range(59);
      end else begin
        op = 1'($urandom);
        y  = $urandom;
        m  = $urandom;
        d  = $urandom;
        h  = $urandom;
        n  = $urandom;
        s  = $urandom;
      end
      send_datetime_op(op, 14'(y), 4'(m), 10'(d), 5'(h), 6'(n), 6'(s));
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/cda_pkg.sv
hdl/cda_leap.sv
hdl/cda_datapath.sv
hdl/cda_sequencer.sv
hdl/calendar_datetime_adder.sv
tb/sv/calendar_datetime_checker.sv
tb/sv/tb_calendar_datetime_adder.sv
